// ===== design/usm_pkg.sv =====
// shared types and constants for the unsharp mask pixel combiner
`default_nettype none

package usm_pkg;

    localparam int NUM_CH = 3;
    localparam int LAT    = 8;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_AMOUNT    = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_MODE      = 2'd2,
        REG_CHANNEL   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_UNSHARP  = 1'b0,
        MODE_HIGHPASS = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CH_ALL    = 2'd0,
        CH_LUMA   = 2'd1,
        CH_CHROMA = 2'd2
    } t_chan_sel;

    localparam logic [15:0] AMOUNT_RST    = 16'd10240;
    localparam logic [15:0] THRESHOLD_RST = 16'd0;

    // luma weights in q8: blue, green, red
    localparam logic signed [8:0] LUMA_W [NUM_CH] = '{9'sd29, 9'sd150, 9'sd77};
    localparam logic signed [17:0] LUMA_FULL = 18'sd65280;

    localparam int P_W    = 34;
    localparam int PROD_W = 50;
    localparam int SHIFT  = 26;
    localparam int S_W    = PROD_W - SHIFT;

    // rounding halves: 255 * 2^25 and 2^25
    localparam logic [PROD_W-1:0] HALF_USM = 50'd8556380160;
    localparam logic [PROD_W-1:0] HALF_HP  = 50'd33554432;

    // floor division by 255 through a reciprocal, exact for n below 132626
    localparam logic [16:0] USM_OFFSET  = 17'd65025;
    localparam logic [16:0] USM_N_MAX   = 17'd130305;
    localparam logic [17:0] RECIP_255   = 18'd131587;
    localparam int          RECIP_SHIFT = 25;

    typedef struct packed {
        logic [2:0][7:0] orig;
        logic [2:0][7:0] base;
        logic [15:0]     mag;
        logic            pass;
    } t_side;

endpackage

`default_nettype wire

// ===== design/unsharp_mask_pixel_combiner_top.sv =====
// Unsharp mask pixel combiner: per-pixel detail, threshold test, sharpening and clamping.
// The block takes one original/blurred BGR pixel pair per clock and returns one
// result for each pair; a full throughput of one pixel per clock is held as
// long as the output side takes results. It is an eight-stage pipeline:
// detail and luma detail, operand selection and threshold test, the halo
// product or high-pass term, two partial products against the amount, their
// sum with the rounding half, the scaling shift and clamp, the reciprocal
// multiply for the division by 255, and the final add and clamp in the output register.
// When the output is stalled the whole pipeline holds and input ready drops in the same
// cycle. Configuration writes are taken at any time and act at once on the pixels
// in the stages that use them; they should be made with the pipeline empty.
`default_nettype none

module unsharp_mask_pixel_combiner_top
    import usm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_orig_blue,
    input  wire logic [7:0]  i_orig_green,
    input  wire logic [7:0]  i_orig_red,
    input  wire logic [7:0]  i_blur_blue,
    input  wire logic [7:0]  i_blur_green,
    input  wire logic [7:0]  i_blur_red,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_red,
    output logic             o_was_sharpened,
    output logic [15:0]      o_luma_detail_mag
);

    // configuration registers
    logic [15:0] r_amount;
    logic [15:0] r_threshold;
    logic        r_mode;
    logic [1:0]  r_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount    <= AMOUNT_RST;
            r_threshold <= THRESHOLD_RST;
            r_mode      <= MODE_UNSHARP;
            r_chan      <= CH_LUMA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AMOUNT:    r_amount    <= i_cfg_data;
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_MODE:      r_mode      <= i_cfg_data[0];
                REG_CHANNEL:   r_chan      <= i_cfg_data[1:0];
                default:       r_amount    <= r_amount;
            endcase
        end
    end

    // pipeline control
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // stage 1: channel details and luma detail
    logic [2:0][7:0]    w_orig;
    logic [2:0][7:0]    w_blur;
    logic signed [8:0]  w_d [NUM_CH];
    logic signed [17:0] w_dyq;

    logic [2:0][7:0]    r_s1_orig;
    logic [2:0][7:0]    r_s1_blur;
    logic signed [8:0]  r_s1_d [NUM_CH];
    logic signed [17:0] r_s1_dyq;

    assign w_orig = {i_orig_red, i_orig_green, i_orig_blue};
    assign w_blur = {i_blur_red, i_blur_green, i_blur_blue};

    always_comb begin
        w_dyq = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            w_d[c] = $signed({1'b0, w_orig[c]}) - $signed({1'b0, w_blur[c]});
            w_dyq  = w_dyq + 18'(w_d[c]) * 18'(LUMA_W[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_orig <= w_orig;
            r_s1_blur <= w_blur;
            r_s1_d    <= w_d;
            r_s1_dyq  <= w_dyq;
        end
    end

    // stage 2: magnitude, threshold test and operand selection
    logic [17:0]        w_abs_dyq;
    t_side              w_s2_side;
    logic signed [17:0] w_x [NUM_CH];
    logic signed [17:0] w_ax [NUM_CH];
    logic signed [17:0] w_h [NUM_CH];
    logic signed [25:0] w_t [NUM_CH];
    logic signed [25:0] w_dyw [NUM_CH];

    t_side              r_s2_side;
    logic signed [17:0] r_s2_x [NUM_CH];
    logic signed [17:0] r_s2_h [NUM_CH];
    logic signed [25:0] r_s2_t [NUM_CH];

    always_comb begin
        w_abs_dyq      = r_s1_dyq < 0 ? 18'(-r_s1_dyq) : 18'(r_s1_dyq);
        w_s2_side.orig = r_s1_orig;
        w_s2_side.base = (r_mode == MODE_HIGHPASS) ? r_s1_blur : r_s1_orig;
        w_s2_side.mag  = w_abs_dyq[15:0];
        w_s2_side.pass = (r_amount == '0) || (w_abs_dyq[15:0] < r_threshold);
        for (int c = 0; c < NUM_CH; c++) begin
            w_dyw[c] = 26'(r_s1_dyq) * 26'(LUMA_W[c]);
            case (r_chan)
                CH_LUMA: begin
                    w_x[c] = r_s1_dyq;
                    w_t[c] = w_dyw[c];
                end
                CH_CHROMA: begin
                    w_x[c] = (18'(r_s1_d[c]) <<< 8) - r_s1_dyq;
                    w_t[c] = (26'(r_s1_d[c]) <<< 16) - w_dyw[c];
                end
                default: begin
                    w_x[c] = 18'(r_s1_d[c]) <<< 8;
                    w_t[c] = 26'(r_s1_d[c]) <<< 16;
                end
            endcase
            w_ax[c] = w_x[c] < 0 ? -w_x[c] : w_x[c];
            w_h[c]  = LUMA_FULL - w_ax[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side <= w_s2_side;
            r_s2_x    <= w_x;
            r_s2_h    <= w_h;
            r_s2_t    <= w_t;
        end
    end

    // stage 3: halo product or high-pass term
    t_side                 r_s3_side;
    logic signed [P_W-1:0] r_s3_p [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_side <= r_s2_side;
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_mode == MODE_HIGHPASS) begin
                    r_s3_p[c] <= P_W'(r_s2_t[c]);
                end else begin
                    r_s3_p[c] <= P_W'(r_s2_x[c]) * P_W'(r_s2_h[c]);
                end
            end
        end
    end

    // stage 4: amount times the term, as two partial products
    t_side              r_s4_side;
    logic [32:0]        r_s4_lo [NUM_CH];
    logic signed [33:0] r_s4_hi [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_side <= r_s3_side;
            for (int c = 0; c < NUM_CH; c++) begin
                r_s4_lo[c] <= 33'(r_amount) * 33'(r_s3_p[c][16:0]);
                r_s4_hi[c] <= 34'($signed({1'b0, r_amount})) * 34'($signed(r_s3_p[c][P_W-1:17]));
            end
        end
    end

    // stage 5: partial product sum plus rounding half
    t_side                    r_s5_side;
    logic signed [PROD_W-1:0] r_s5_sum [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_side <= r_s4_side;
            for (int c = 0; c < NUM_CH; c++) begin
                r_s5_sum[c] <= (PROD_W'(r_s4_hi[c]) <<< 17) + PROD_W'(r_s4_lo[c])
                             + ((r_mode == MODE_HIGHPASS) ? HALF_HP : HALF_USM);
            end
        end
    end

    // stage 6: scale down and clamp to the useful range
    logic signed [S_W-1:0] w_s [NUM_CH];
    logic [16:0]           w_n [NUM_CH];
    logic signed [9:0]     w_q [NUM_CH];

    t_side                 r_s6_side;
    logic [16:0]           r_s6_n [NUM_CH];
    logic signed [9:0]     r_s6_q [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_s[c] = S_W'(r_s5_sum[c] >>> SHIFT);
            if (w_s[c] < -$signed(S_W'(USM_OFFSET))) begin
                w_n[c] = '0;
            end else if (w_s[c] > $signed(S_W'(LUMA_FULL))) begin
                w_n[c] = USM_N_MAX;
            end else begin
                w_n[c] = 17'(w_s[c] + $signed(S_W'(USM_OFFSET)));
            end
            if (w_s[c] < -24'sd256) begin
                w_q[c] = -10'sd256;
            end else if (w_s[c] > 24'sd256) begin
                w_q[c] = 10'sd256;
            end else begin
                w_q[c] = 10'(w_s[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_side <= r_s5_side;
            r_s6_n    <= w_n;
            r_s6_q    <= w_q;
        end
    end

    // stage 7: division by 255 via reciprocal
    t_side             r_s7_side;
    logic [34:0]       r_s7_prod [NUM_CH];
    logic signed [9:0] r_s7_q [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_side <= r_s6_side;
            r_s7_q    <= r_s6_q;
            for (int c = 0; c < NUM_CH; c++) begin
                r_s7_prod[c] <= 35'(r_s6_n[c]) * 35'(RECIP_255);
            end
        end
    end

    // stage 8: final add, clamp and output register
    logic signed [10:0] w_qu [NUM_CH];
    logic signed [10:0] w_qs [NUM_CH];
    logic signed [10:0] w_r [NUM_CH];
    logic [2:0][7:0]    w_pix;

    logic [2:0][7:0]    r_out_pix;
    logic               r_out_sharp;
    logic [15:0]        r_out_mag;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_qu[c] = $signed({1'b0, r_s7_prod[c][RECIP_SHIFT+9:RECIP_SHIFT]}) - 11'sd255;
            w_qs[c] = (r_mode == MODE_HIGHPASS) ? 11'(r_s7_q[c]) : w_qu[c];
            w_r[c]  = $signed({3'b000, r_s7_side.base[c]}) + w_qs[c];
            if (r_s7_side.pass) begin
                w_pix[c] = r_s7_side.orig[c];
            end else if (w_r[c] < 0) begin
                w_pix[c] = 8'd0;
            end else if (w_r[c] > 11'sd255) begin
                w_pix[c] = 8'd255;
            end else begin
                w_pix[c] = w_r[c][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pix   <= w_pix;
            r_out_sharp <= !r_s7_side.pass;
            r_out_mag   <= r_s7_side.mag;
        end
    end

    assign o_out_valid       = r_vld[LAT-1];
    assign o_out_blue        = r_out_pix[0];
    assign o_out_green       = r_out_pix[1];
    assign o_out_red         = r_out_pix[2];
    assign o_was_sharpened   = r_out_sharp;
    assign o_luma_detail_mag = r_out_mag;

    // pipeline holds its valid bits while stalled
    a_stall_hold: assert property (@(posedge i_clk)
        i_rst_n && !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // first stage valid follows the accepted request
    a_entry: assert property (@(posedge i_clk)
        i_rst_n && w_en |=> r_vld[0] == $past(i_in_valid))
        else $error("stage one valid does not match the request");

    // a result appears only from a valid last inner stage
    a_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[LAT-2]) && $past(w_en))
        else $error("result appeared without a request behind it");

    // the stall only happens with a result waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without an output stall");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the unsharp mask pixel combiner
`timescale 1ns / 1ps

module testbench;
    import usm_pkg::*;

    localparam int     CYCLE_LIMIT = 200000;
    localparam longint DEN_HIGHPASS = 64'd67108864;
    localparam longint DEN_UNSHARP  = 64'd67108864 * 64'd255;

    typedef struct packed {
        logic [2:0][7:0] orig;
        logic [2:0][7:0] blur;
    } t_pixel_pair;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        sharpened;
        logic [15:0] mag;
    } t_sharp_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_orig_blue;
    logic [7:0]  i_orig_green;
    logic [7:0]  i_orig_red;
    logic [7:0]  i_blur_blue;
    logic [7:0]  i_blur_green;
    logic [7:0]  i_blur_red;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_red;
    logic        o_was_sharpened;
    logic [15:0] o_luma_detail_mag;

    logic [15:0] amount_q10;
    logic [15:0] threshold_q8;
    t_mode       sharp_mode;
    logic [1:0]  chan_sel;

    t_pixel_pair  pending_pixels [$];
    t_sharp_pixel expected_pixels [$];
    t_pixel_pair  cur_pixel;
    bit           steady;
    int           error_count;
    int           result_count;
    int           cycle_count;

    unsharp_mask_pixel_combiner_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_orig_blue       (i_orig_blue),
        .i_orig_green      (i_orig_green),
        .i_orig_red        (i_orig_red),
        .i_blur_blue       (i_blur_blue),
        .i_blur_green      (i_blur_green),
        .i_blur_red        (i_blur_red),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_blue        (o_out_blue),
        .o_out_green       (o_out_green),
        .o_out_red         (o_out_red),
        .o_was_sharpened   (o_was_sharpened),
        .o_luma_detail_mag (o_luma_detail_mag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] round_to_byte(longint base, longint num, longint den);
        longint v;
        v = base * den + num;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255 * den) begin
            v = 255 * den;
        end
        v = (v + den / 2) / den;
        return v[7:0];
    endfunction

    function automatic t_sharp_pixel sharpen_pixel(t_pixel_pair p);
        longint       detail [3];
        logic [7:0]   res [3];
        longint       dyq;
        longint       mag;
        longint       amt;
        longint       x;
        longint       t;
        longint       w;
        t_sharp_pixel r;
        dyq = 0;
        amt = longint'(amount_q10);
        for (int c = 0; c < NUM_CH; c++) begin
            detail[c] = longint'(p.orig[c]) - longint'(p.blur[c]);
            dyq += longint'(LUMA_W[c]) * detail[c];
        end
        mag = (dyq < 0) ? -dyq : dyq;
        r.mag = mag[15:0];
        if (amt == 0 || mag < longint'(threshold_q8)) begin
            r.sharpened = 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                res[c] = p.orig[c];
            end
        end else begin
            r.sharpened = 1'b1;
            for (int c = 0; c < NUM_CH; c++) begin
                w = longint'(LUMA_W[c]);
                if (sharp_mode == MODE_UNSHARP) begin
                    if (chan_sel == CH_LUMA) begin
                        x = dyq;
                    end else if (chan_sel == CH_CHROMA) begin
                        x = 256 * detail[c] - dyq;
                    end else begin
                        x = 256 * detail[c];
                    end
                    res[c] = round_to_byte(longint'(p.orig[c]),
                        amt * x * (longint'(LUMA_FULL) - ((x < 0) ? -x : x)), DEN_UNSHARP);
                end else begin
                    if (chan_sel == CH_LUMA) begin
                        t = dyq * w;
                    end else if (chan_sel == CH_CHROMA) begin
                        t = 65536 * detail[c] - dyq * w;
                    end else begin
                        t = 65536 * detail[c];
                    end
                    res[c] = round_to_byte(longint'(p.blur[c]), amt * t, DEN_HIGHPASS);
                end
            end
        end
        r.blue  = res[0];
        r.green = res[1];
        r.red   = res[2];
        return r;
    endfunction

    function automatic t_pixel_pair random_pixel();
        t_pixel_pair p;
        int          kind;
        int          b;
        kind = $urandom_range(9);
        for (int c = 0; c < NUM_CH; c++) begin
            p.orig[c] = 8'($urandom_range(255));
            if (kind <= 3) begin
                p.blur[c] = 8'($urandom_range(255));
            end else if (kind <= 7) begin
                // small detail around the threshold
                b = int'(p.orig[c]) + int'($urandom_range(24)) - 12;
                b = (b < 0) ? 0 : ((b > 255) ? 255 : b);
                p.blur[c] = 8'(b);
            end else if (kind == 8) begin
                p.orig[c] = $urandom_range(1) ? 8'd255 : 8'd0;
                p.blur[c] = $urandom_range(1) ? 8'd255 : 8'd0;
            end else begin
                p.blur[c] = p.orig[c];
            end
        end
        return p;
    endfunction

    function automatic t_pixel_pair make_pixel(logic [7:0] ob, logic [7:0] og, logic [7:0] orr,
                                               logic [7:0] bb, logic [7:0] bg, logic [7:0] br);
        t_pixel_pair p;
        p.orig = {orr, og, ob};
        p.blur = {br, bg, bb};
        return p;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at result %0d: %s", result_count, what);
        error_count++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_AMOUNT: begin
                amount_q10 = value;
            end
            REG_THRESHOLD: begin
                threshold_q8 = value;
            end
            REG_MODE: begin
                sharp_mode = t_mode'(value[0]);
            end
            default: begin
                chan_sel = value[1:0];
            end
        endcase
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_in_valid || expected_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] amount, logic [15:0] thr, t_mode m, logic [1:0] sel);
        settle();
        write_reg(REG_AMOUNT, amount);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MODE, {15'd0, m});
        write_reg(REG_CHANNEL, {14'd0, sel});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] amount, logic [15:0] thr, t_mode m, logic [1:0] sel,
                             int n, bit calm);
        configure(amount, thr, m, sel);
        steady = calm;
        for (int k = 0; k < n; k++) begin
            pending_pixels.push_back(random_pixel());
        end
        settle();
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_pixels.push_back(sharpen_pixel(cur_pixel));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
                    cur_pixel = pending_pixels.pop_front();
                    i_in_valid   <= 1'b1;
                    i_orig_blue  <= cur_pixel.orig[0];
                    i_orig_green <= cur_pixel.orig[1];
                    i_orig_red   <= cur_pixel.orig[2];
                    i_blur_blue  <= cur_pixel.blur[0];
                    i_blur_green <= cur_pixel.blur[1];
                    i_blur_red   <= cur_pixel.blur[2];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_sharp_pixel want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with no pixel pending");
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_blue !== want.blue) begin
                        report_mismatch($sformatf("blue %0d, expected %0d", o_out_blue, want.blue));
                    end
                    if (o_out_green !== want.green) begin
                        report_mismatch($sformatf("green %0d, expected %0d",
                            o_out_green, want.green));
                    end
                    if (o_out_red !== want.red) begin
                        report_mismatch($sformatf("red %0d, expected %0d", o_out_red, want.red));
                    end
                    if (o_was_sharpened !== want.sharpened) begin
                        report_mismatch($sformatf("was_sharpened %0b, expected %0b",
                            o_was_sharpened, want.sharpened));
                    end
                    if (o_luma_detail_mag !== want.mag) begin
                        report_mismatch($sformatf("luma_detail_mag %0d, expected %0d",
                            o_luma_detail_mag, want.mag));
                    end
                end
                result_count++;
            end
            i_out_ready <= steady || $urandom_range(99) >= 21;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_AMOUNT;
        i_cfg_data   = 16'd0;
        i_in_valid   = 1'b0;
        i_out_ready  = 1'b0;
        i_orig_blue  = 8'd0;
        i_orig_green = 8'd0;
        i_orig_red   = 8'd0;
        i_blur_blue  = 8'd0;
        i_blur_green = 8'd0;
        i_blur_red   = 8'd0;
        amount_q10   = AMOUNT_RST;
        threshold_q8 = THRESHOLD_RST;
        sharp_mode   = MODE_UNSHARP;
        chan_sel     = CH_LUMA;
        steady       = 1'b0;
        error_count  = 0;
        result_count = 0;
        cycle_count  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale details through every mode and channel selection
        for (int m = 0; m < 2; m++) begin
            for (int s = 0; s < 4; s++) begin
                configure(AMOUNT_RST, 16'd0, t_mode'(m), 2'(s));
                pending_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
                pending_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
                pending_pixels.push_back(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
            end
        end

        run_phase(AMOUNT_RST, THRESHOLD_RST, MODE_UNSHARP, CH_LUMA, 75, 1'b0);
        run_phase(16'd0, 16'd0, MODE_HIGHPASS, CH_ALL, 60, 1'b0);
        run_phase(16'd65535, 16'd0, MODE_HIGHPASS, CH_ALL, 75, 1'b0);
        run_phase(16'd40960, 16'd65280, MODE_UNSHARP, CH_CHROMA, 60, 1'b0);
        run_phase(16'd1, 16'd1, MODE_HIGHPASS, 2'd3, 75, 1'b0);
        run_phase(16'd20480, 16'd2048, MODE_UNSHARP, CH_ALL, 150, 1'b1);
        run_phase(16'd65535, 16'd65535, MODE_UNSHARP, CH_CHROMA, 50, 1'b0);
        run_phase(16'd40960, 16'd0, MODE_UNSHARP, CH_ALL, 75, 1'b0);
        for (int k = 0; k < 4; k++) begin
            run_phase(16'($urandom_range(40960)), 16'($urandom_range(4096)),
                      t_mode'($urandom_range(1)), 2'($urandom_range(3)), 30, 1'b0);
        end

        settle();
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/usm_pkg.sv
design/unsharp_mask_pixel_combiner_top.sv
test/testbench.sv
